// ----- rtl/core/assert_macros.svh -----
// assertion macros for the rtl file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while rst_n is low
`define BAFD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bearing unit assertion failed");

// implication form: the consequent must hold in the same cycle as the antecedent
`define BAFD_ASSERT_IMPL(label, ante, cons) \
    `BAFD_ASSERT(label, (ante) |-> (cons))

`endif

// ----- rtl/core/bafd_pkg.sv -----
// shared constants, types and the arctangent table of the bearing unit
`default_nettype none

package bafd_pkg;

    // coordinate and difference widths
    localparam int COORD_BITS = 16;
    localparam int DW         = COORD_BITS + 1;

    // cordic step count
    localparam int ANGLE_STEPS = 16;
    localparam int MAX_STEPS   = 24;
    localparam int NUM_STEPS   = (ANGLE_STEPS < MAX_STEPS) ? ANGLE_STEPS : MAX_STEPS;
    localparam int STEP_W      = $clog2(MAX_STEPS);

    // normalization puts the larger operand's top bit here
    localparam int NORM_BIT = 40;
    localparam int SH_W     = $clog2(NORM_BIT + 1);

    // datapath widths: x, y keep headroom for the cordic gain
    localparam int XW     = NORM_BIT + 4;
    localparam int ATAN_W = 22;
    localparam int ZW     = 25;
    localparam int ZCW    = 23;
    localparam int PHI_W  = 15;

    localparam int BEARING_W = 17;

    // angle constants, degrees * 65536 and degrees * 256
    localparam logic signed [ZW-1:0]  DEG90_Q16 = ZW'(90 * 65536);
    localparam logic [BEARING_W-1:0]  DEG90     = BEARING_W'(90 * 256);
    localparam logic [BEARING_W-1:0]  DEG180    = BEARING_W'(180 * 256);
    localparam logic [BEARING_W-1:0]  DEG270    = BEARING_W'(270 * 256);
    localparam logic [BEARING_W-1:0]  DEG360    = BEARING_W'(360 * 256);
    localparam logic [ZCW:0]          ROUND_HALF = (ZCW + 1)'(128);

    // atan(2^-i) in degrees * 65536, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_TABLE [MAX_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    // case flags that travel alongside the datapath
    typedef struct packed {
        logic degen;
        logic dx_zero;
        logic dy_zero;
        logic dx_neg;
        logic dy_neg;
    } info_t;

    // state handed from one cordic cell to the next
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        info_t                info;
    } cordic_t;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        val = '0;
        if (int'(idx) < MAX_STEPS)
        begin
            val = ATAN_TABLE[idx];
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bafd_front.sv -----
// front end: coordinate differences, quadrant folding and normalization
`default_nettype none

module bafd_front (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [bafd_pkg::COORD_BITS-1:0]  target_y,
    input  wire logic signed [bafd_pkg::COORD_BITS-1:0]  own_y,
    input  wire logic signed [bafd_pkg::COORD_BITS-1:0]  target_x,
    input  wire logic signed [bafd_pkg::COORD_BITS-1:0]  own_x,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output bafd_pkg::cordic_t                            out_data
);

    // index of the highest set bit, zero for an all-zero word
    function automatic logic [bafd_pkg::SH_W-1:0] msb_pos(
        input logic [bafd_pkg::DW-1:0] m
    );
        logic [bafd_pkg::SH_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < bafd_pkg::DW; i++)
        begin
            if (m[i])
            begin
                pos = bafd_pkg::SH_W'(i);
            end
        end
        return pos;
    endfunction

    logic                              a_valid_reg;
    logic signed [bafd_pkg::DW-1:0]    dx_reg;
    logic signed [bafd_pkg::DW-1:0]    dy_reg;
    logic                              a_ready;

    logic                              b_valid_reg;
    logic [bafd_pkg::DW-1:0]           u_reg;
    logic [bafd_pkg::DW-1:0]           v_reg;
    logic [bafd_pkg::SH_W-1:0]         sh_reg;
    bafd_pkg::info_t                   b_info_reg;
    logic                              b_ready;

    logic                              c_valid_reg;
    bafd_pkg::cordic_t                 c_data_reg;
    logic                              c_ready;

    logic signed [bafd_pkg::DW-1:0]    dx_next;
    logic signed [bafd_pkg::DW-1:0]    dy_next;
    logic [bafd_pkg::DW-1:0]           u_next;
    logic [bafd_pkg::DW-1:0]           v_next;
    logic [bafd_pkg::DW-1:0]           max_uv;
    logic [bafd_pkg::SH_W-1:0]         sh_next;
    bafd_pkg::info_t                   info_next;
    bafd_pkg::cordic_t                 c_data_next;

    // per-stage ready chain
    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: differences
    assign dy_next = bafd_pkg::DW'(target_y) - bafd_pkg::DW'(own_y);
    assign dx_next = bafd_pkg::DW'(target_x) - bafd_pkg::DW'(own_x);

    // stage b: fold into first quadrant and find the normalizing shift
    always_comb
    begin
        u_next = dx_reg[bafd_pkg::DW-1] ? (~dx_reg + 1'b1) : dx_reg;
        v_next = dy_reg[bafd_pkg::DW-1] ? (~dy_reg + 1'b1) : dy_reg;
        max_uv = (u_next > v_next) ? u_next : v_next;
        if (max_uv == '0)
        begin
            sh_next = '0;
        end
        else
        begin
            sh_next = bafd_pkg::SH_W'(bafd_pkg::NORM_BIT) - msb_pos(max_uv);
        end
        info_next.dx_zero = (dx_reg == '0);
        info_next.dy_zero = (dy_reg == '0);
        info_next.degen   = (dx_reg == '0) && (dy_reg == '0);
        info_next.dx_neg  = dx_reg[bafd_pkg::DW-1];
        info_next.dy_neg  = dy_reg[bafd_pkg::DW-1];
    end

    // stage c: shift both operands, x takes |dy| and y takes |dx|
    always_comb
    begin
        c_data_next.x    = signed'({{(bafd_pkg::XW-bafd_pkg::DW){1'b0}}, v_reg} << sh_reg);
        c_data_next.y    = signed'({{(bafd_pkg::XW-bafd_pkg::DW){1'b0}}, u_reg} << sh_reg);
        c_data_next.z    = '0;
        c_data_next.info = b_info_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (b_ready && a_valid_reg)
        begin
            u_reg      <= u_next;
            v_reg      <= v_next;
            sh_reg     <= sh_next;
            b_info_reg <= info_next;
        end
        if (c_ready && b_valid_reg)
        begin
            c_data_reg <= c_data_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bafd_cell.sv -----
// one cordic vectoring step with its own pipeline register
`default_nettype none

module bafd_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [bafd_pkg::STEP_W-1:0]   step,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire bafd_pkg::cordic_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bafd_pkg::cordic_t                  out_data
);

    logic                              valid_reg;
    bafd_pkg::cordic_t                 data_reg;
    bafd_pkg::cordic_t                 data_next;
    logic signed [bafd_pkg::XW-1:0]    xs;
    logic signed [bafd_pkg::XW-1:0]    ys;
    logic signed [bafd_pkg::ZW-1:0]    dz;

    assign in_ready = !valid_reg || out_ready;

    // rotate toward the x axis, old x and y feed both updates
    always_comb
    begin
        xs = in_data.x >>> step;
        ys = in_data.y >>> step;
        dz = signed'({{(bafd_pkg::ZW-bafd_pkg::ATAN_W){1'b0}}, bafd_pkg::atan_q16(step)});
        data_next.info = in_data.info;
        if (in_data.y > 0)
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + dz;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - dz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bafd_back.sv -----
// back end: clamp and round the angle, unfold by quadrant, output register
`default_nettype none

module bafd_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire bafd_pkg::cordic_t                 in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [bafd_pkg::BEARING_W-1:0]         bearing,
    output logic                                   degenerate
);

    logic                                  p_valid_reg;
    logic [bafd_pkg::PHI_W-1:0]            phi_reg;
    bafd_pkg::info_t                       p_info_reg;
    logic                                  p_ready;

    logic                                  q_valid_reg;
    logic [bafd_pkg::BEARING_W-1:0]        bearing_reg;
    logic                                  degen_reg;
    logic                                  q_ready;

    logic [bafd_pkg::ZCW-1:0]              zc;
    logic [bafd_pkg::ZCW:0]                zr;
    logic [bafd_pkg::PHI_W-1:0]            phi_next;
    logic [bafd_pkg::BEARING_W-1:0]        phi_ext;
    logic [bafd_pkg::BEARING_W-1:0]        b_raw;
    logic [bafd_pkg::BEARING_W-1:0]        bearing_next;

    assign q_ready  = !q_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || q_ready;
    assign in_ready = p_ready;

    // clamp to 0..90 degrees, then round q16 to q8
    always_comb
    begin
        if (in_data.z < 0)
        begin
            zc = '0;
        end
        else if (in_data.z > bafd_pkg::DEG90_Q16)
        begin
            zc = bafd_pkg::ZCW'(bafd_pkg::DEG90_Q16);
        end
        else
        begin
            zc = bafd_pkg::ZCW'(in_data.z);
        end
        zr       = {1'b0, zc} + bafd_pkg::ROUND_HALF;
        phi_next = zr[bafd_pkg::PHI_W+7:8];
    end

    // axis cases and quadrant unfolding, full turn wraps to zero
    always_comb
    begin
        phi_ext = bafd_pkg::BEARING_W'(phi_reg);
        if (p_info_reg.degen)
        begin
            b_raw = '0;
        end
        else if (p_info_reg.dx_zero)
        begin
            b_raw = p_info_reg.dy_neg ? bafd_pkg::DEG180 : '0;
        end
        else if (p_info_reg.dy_zero)
        begin
            b_raw = p_info_reg.dx_neg ? bafd_pkg::DEG270 : bafd_pkg::DEG90;
        end
        else if (!p_info_reg.dx_neg)
        begin
            b_raw = p_info_reg.dy_neg ? (bafd_pkg::DEG180 - phi_ext) : phi_ext;
        end
        else
        begin
            b_raw = p_info_reg.dy_neg ? (bafd_pkg::DEG180 + phi_ext)
                                      : (bafd_pkg::DEG360 - phi_ext);
        end
        bearing_next = (b_raw >= bafd_pkg::DEG360) ? (b_raw - bafd_pkg::DEG360) : b_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= in_valid;
            end
            if (q_ready)
            begin
                q_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && in_valid)
        begin
            phi_reg    <= phi_next;
            p_info_reg <= in_data.info;
        end
        if (q_ready && p_valid_reg)
        begin
            bearing_reg <= bearing_next;
            degen_reg   <= p_info_reg.degen;
        end
    end

    assign out_valid  = q_valid_reg;
    assign bearing    = bearing_reg;
    assign degenerate = degen_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bearing_angle_from_deltas.sv -----
// top level of the bearing unit: front end, cordic cell row, back end
`default_nettype none
`include "assert_macros.svh"

// Compass bearing from an observer to a target, degrees * 256, clockwise from +y
// (90 degrees along +x), always below 360. When the two points coincide the
// bearing is 0 and degenerate is set. The unit is a plain pipeline: a new
// transaction can enter every cycle unless the input is stalled as described below, and
// each passes through 21 registered stages (3 front-end stages, one per cordic cell for
// the 16 cells, 2 back-end stages). Every stage has its own valid bit, so bubbles are
// squeezed out; the input stalls only once all 21 stages hold a transaction and the
// result at the output is not taken.
module bearing_angle_from_deltas (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [bafd_pkg::COORD_BITS-1:0]  target_y,
    input  wire logic signed [bafd_pkg::COORD_BITS-1:0]  own_y,
    input  wire logic signed [bafd_pkg::COORD_BITS-1:0]  target_x,
    input  wire logic signed [bafd_pkg::COORD_BITS-1:0]  own_x,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [bafd_pkg::BEARING_W-1:0]               bearing,
    output logic                                         degenerate
);

    logic              link_valid [bafd_pkg::NUM_STEPS+1];
    logic              link_ready [bafd_pkg::NUM_STEPS+1];
    bafd_pkg::cordic_t link_data  [bafd_pkg::NUM_STEPS+1];

    // deltas, folding and normalization
    bafd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .target_y  (target_y),
        .own_y     (own_y),
        .target_x  (target_x),
        .own_x     (own_x),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // row of cordic cells, cell k does step k
    for (genvar k = 0; k < bafd_pkg::NUM_STEPS; k++)
    begin : g_cell
        localparam logic [bafd_pkg::STEP_W-1:0] STEP_IDX = bafd_pkg::STEP_W'(k);

        bafd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_IDX),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_data   (link_data[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_data  (link_data[k+1])
        );
    end

    // rounding, unfolding and output register
    bafd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (link_valid[bafd_pkg::NUM_STEPS]),
        .in_ready   (link_ready[bafd_pkg::NUM_STEPS]),
        .in_data    (link_data[bafd_pkg::NUM_STEPS]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bearing    (bearing),
        .degenerate (degenerate)
    );

    // checks
    `BAFD_ASSERT_IMPL(a_degen_zero, out_valid && degenerate, bearing == '0)
    `BAFD_ASSERT_IMPL(a_bearing_range, out_valid, bearing < bafd_pkg::DEG360)
    `BAFD_ASSERT_IMPL(a_stall_only_when_full, !in_ready, out_valid)
    `BAFD_ASSERT_IMPL(a_normalized, link_valid[0] && !link_data[0].info.degen,
        (link_data[0].x[bafd_pkg::NORM_BIT] || link_data[0].y[bafd_pkg::NORM_BIT]) &&
        ((link_data[0].x >>> (bafd_pkg::NORM_BIT + 1)) == 0) &&
        ((link_data[0].y >>> (bafd_pkg::NORM_BIT + 1)) == 0))

endmodule

`default_nettype wire

// ----- dv/bearing_angle_from_deltas_test.sv -----
// testbench for the bearing unit: directed and random positions against a cordic predictor
module bearing_angle_from_deltas_test;

    localparam int CW         = bafd_pkg::COORD_BITS;
    localparam int BW         = bafd_pkg::BEARING_W;
    localparam int CORDIC_N   = 16;
    localparam int TOP_BIT    = 40;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 40;

    // bearing constants, degrees * 256 (right angle also in degrees * 65536)
    localparam longint RIGHT_Q16  = 90 * 65536;
    localparam longint RIGHT_DEG  = 90 * 256;
    localparam longint HALF_DEG   = 180 * 256;
    localparam longint THREEQ_DEG = 270 * 256;
    localparam longint TURN_DEG   = 360 * 256;

    // atan(2^-i) in degrees * 65536
    localparam longint ARCTAN_Q16 [CORDIC_N] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic [BW-1:0] bearing;
        logic          degenerate;
    } bearing_exp_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [CW-1:0] target_y;
    logic signed [CW-1:0] own_y;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] own_x;
    logic                 out_valid;
    logic                 out_ready;
    logic [BW-1:0]        bearing;
    logic                 degenerate;

    bearing_exp_t pending_bearings [$];
    int           mismatch_count;
    bit           src_idle;
    bit           sink_idle;

    bearing_angle_from_deltas uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .target_y   (target_y),
        .own_y      (own_y),
        .target_x   (target_x),
        .own_x      (own_x),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bearing    (bearing),
        .degenerate (degenerate)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // gap length: mostly none, some short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // expected bearing for one pair of positions
    function automatic bearing_exp_t predict_bearing(input logic signed [CW-1:0] ty, oy, tx, ox);
        bearing_exp_t res;
        longint       dx, dy, x, y, z, xs, ys, phi, b;
        dy             = longint'(ty) - longint'(oy);
        dx             = longint'(tx) - longint'(ox);
        res.degenerate = 1'b0;
        if (dx == 0 && dy == 0)
        begin
            b              = 0;
            res.degenerate = 1'b1;
        end
        else if (dx == 0)
        begin
            b = (dy > 0) ? 0 : HALF_DEG;
        end
        else if (dy == 0)
        begin
            b = (dx > 0) ? RIGHT_DEG : THREEQ_DEG;
        end
        else
        begin
            // fold into the first quadrant and normalize
            x = (dy < 0) ? -dy : dy;
            y = (dx < 0) ? -dx : dx;
            z = 0;
            while (((x > y) ? x : y) < (longint'(1) << TOP_BIT))
            begin
                x = x << 1;
                y = y << 1;
            end
            // vectoring iterations
            for (int i = 0; i < CORDIC_N; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ARCTAN_Q16[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ARCTAN_Q16[i];
                end
            end
            if (z < 0)
            begin
                z = 0;
            end
            if (z > RIGHT_Q16)
            begin
                z = RIGHT_Q16;
            end
            phi = (z + 128) >>> 8;
            // unfold by quadrant
            if (dx > 0)
            begin
                b = (dy > 0) ? phi : HALF_DEG - phi;
            end
            else
            begin
                b = (dy < 0) ? HALF_DEG + phi : TURN_DEG - phi;
            end
        end
        if (b >= TURN_DEG)
        begin
            b = b - TURN_DEG;
        end
        if (b < 0)
        begin
            b = 0;
        end
        res.bearing = b[BW-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // send one transaction and record its expected bearing
    task automatic drive_positions(input logic signed [CW-1:0] ty, oy, tx, ox);
        int gap;
        gap = src_idle ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        target_y <= ty;
        own_y    <= oy;
        target_x <= tx;
        own_x    <= ox;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_bearings.push_back(predict_bearing(ty, oy, tx, ox));
    endtask

    // place a difference vector at the edges of the coordinate range
    task automatic drive_delta(input int dx, input int dy);
        int ox, oy;
        ox = (dx >= 0) ? -32768 : 32767;
        oy = (dy >= 0) ? -32768 : 32767;
        drive_positions(CW'(oy + dy), CW'(oy), CW'(ox + dx), CW'(ox));
    endtask

    task automatic test_coincident();
        drive_positions(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        drive_positions(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        drive_positions(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        drive_positions(16'sd1234, 16'sd1234, -16'sd555, -16'sd555);
    endtask

    task automatic test_axes();
        drive_positions(16'sd1, 16'sd0, 16'sd5, 16'sd5);
        drive_delta(0, 65535);
        drive_delta(0, -65535);
        drive_delta(65535, 0);
        drive_delta(-65535, 0);
        drive_positions(16'sd7, 16'sd7, -16'sd1, 16'sd0);
    endtask

    task automatic test_quadrants();
        drive_delta(1000, 1000);
        drive_delta(1000, -1000);
        drive_delta(-1000, -1000);
        drive_delta(-1000, 1000);
        // near the axes, including clamping and the wrap at a full turn
        drive_delta(65535, 1);
        drive_delta(1, 65535);
        drive_delta(1, -65535);
        drive_delta(65535, -1);
        drive_delta(-65535, -1);
        drive_delta(-1, -65535);
        drive_delta(-1, 65535);
        drive_delta(-65535, 1);
    endtask

    // random mix of wide, close, axis, coincident and extreme positions
    task automatic test_random_positions(input int count);
        int                   kind, ox, oy, dx, dy;
        logic signed [CW-1:0] ty, tx, oyv, oxv;
        int                   corner [7];
        corner = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                ty  = CW'($urandom());
                oyv = CW'($urandom());
                tx  = CW'($urandom());
                oxv = CW'($urandom());
            end
            else if (kind < 65)
            begin
                ox  = int'($urandom_range(0, 60000)) - 30000;
                oy  = int'($urandom_range(0, 60000)) - 30000;
                dx  = int'($urandom_range(0, 1000)) - 500;
                dy  = int'($urandom_range(0, 1000)) - 500;
                oxv = CW'(ox);
                oyv = CW'(oy);
                tx  = CW'(ox + dx);
                ty  = CW'(oy + dy);
            end
            else if (kind < 75)
            begin
                oxv = CW'($urandom());
                oyv = CW'($urandom());
                tx  = CW'($urandom());
                ty  = CW'($urandom());
                if ($urandom_range(0, 1))
                begin
                    tx = oxv;
                end
                else
                begin
                    ty = oyv;
                end
            end
            else if (kind < 80)
            begin
                oxv = CW'($urandom());
                oyv = CW'($urandom());
                tx  = oxv;
                ty  = oyv;
            end
            else
            begin
                ty  = CW'(corner[$urandom_range(0, 6)]);
                oyv = CW'(corner[$urandom_range(0, 6)]);
                tx  = CW'(corner[$urandom_range(0, 6)]);
                oxv = CW'(corner[$urandom_range(0, 6)]);
            end
            drive_positions(ty, oyv, tx, oxv);
        end
    endtask

    // result side backpressure
    initial
    begin
        int n;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            n = sink_idle ? idle_length() : 0;
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        bearing_exp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bearings.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result bearing=%0d degenerate=%0b",
                                        bearing, degenerate));
            end
            else
            begin
                want = pending_bearings.pop_front();
                if (bearing !== want.bearing)
                begin
                    flag_mismatch($sformatf("bearing %0d, expected %0d",
                                            bearing, want.bearing));
                end
                if (degenerate !== want.degenerate)
                begin
                    flag_mismatch($sformatf("degenerate %0b, expected %0b",
                                            degenerate, want.degenerate));
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("FAIL bearing_angle_from_deltas");
        $finish;
    end

    // main sequence
    initial
    begin
        mismatch_count = 0;
        src_idle       = 1'b1;
        sink_idle      = 1'b1;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        target_y <= '0;
        own_y    <= '0;
        target_x <= '0;
        own_x    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coincident();
        test_axes();
        test_quadrants();

        // idling on both sides, then full rate, then result stalls only
        test_random_positions(600);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        test_random_positions(400);
        sink_idle = 1'b1;
        test_random_positions(425);

        in_valid <= 1'b0;
        while (pending_bearings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("PASS bearing_angle_from_deltas");
        end
        else
        begin
            $display("FAIL bearing_angle_from_deltas");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bafd_pkg.sv
rtl/core/bafd_front.sv
rtl/core/bafd_cell.sv
rtl/core/bafd_back.sv
rtl/core/bearing_angle_from_deltas.sv
dv/bearing_angle_from_deltas_test.sv
